// ===== sv/tvg_pkg.sv =====
`default_nettype none

package tvg_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int COF_W   = PROD_W + 1;
    localparam int GRAD_W  = 36;
    localparam int DET_W   = 52;
    localparam int CORNER_W = 2;

    localparam logic [CORNER_W-1:0] CORNER_D = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [COF_W-1:0]   t_cof;
    typedef logic signed [GRAD_W-1:0]  t_grad;
    typedef logic signed [DET_W-1:0]   t_det;

    // cofactor matrix (row = coordinate, column = corner) plus top row of the matrix
    typedef struct packed {
        logic [2:0][2:0][COF_W-1:0] cof;
        logic [2:0][DIFF_W-1:0]     m0;
    } t_cof_bus;

    // per-corner gradients and the determinant
    typedef struct packed {
        logic [3:0][2:0][GRAD_W-1:0] grad;
        logic [DET_W-1:0]            det;
    } t_res_bus;

endpackage

`default_nettype wire

// ===== sv/tvg_in_if.sv =====
`default_nettype none

interface tvg_in_if;
    logic            valid;
    logic            ready;
    tvg_pkg::t_coord a_x;
    tvg_pkg::t_coord a_y;
    tvg_pkg::t_coord a_z;
    tvg_pkg::t_coord b_x;
    tvg_pkg::t_coord b_y;
    tvg_pkg::t_coord b_z;
    tvg_pkg::t_coord c_x;
    tvg_pkg::t_coord c_y;
    tvg_pkg::t_coord c_z;
    tvg_pkg::t_coord d_x;
    tvg_pkg::t_coord d_y;
    tvg_pkg::t_coord d_z;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/tvg_out_if.sv =====
`default_nettype none

interface tvg_out_if;
    logic                                valid;
    logic                                ready;
    logic [tvg_pkg::CORNER_W-1:0]        corner;
    tvg_pkg::t_grad                      grad_x;
    tvg_pkg::t_grad                      grad_y;
    tvg_pkg::t_grad                      grad_z;
    tvg_pkg::t_det                       six_volume;
    logic                                last;

    modport source (
        output valid, corner, grad_x, grad_y, grad_z, six_volume, last,
        input  ready
    );
    modport sink (
        input  valid, corner, grad_x, grad_y, grad_z, six_volume, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/tvg_cofactor.sv =====
`default_nettype none

module tvg_cofactor (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tvg_in_if.sink                 i_in,
    output tvg_pkg::t_cof_bus      o_bus,
    output logic                   o_valid,
    input  wire logic              i_ready
);

    tvg_pkg::t_coord pt [4][3];
    tvg_pkg::t_diff  n_m [3][3];
    tvg_pkg::t_diff  r_m [3][3];
    tvg_pkg::t_prod  n_pa [3][3];
    tvg_pkg::t_prod  n_pb [3][3];
    tvg_pkg::t_prod  r_pa [3][3];
    tvg_pkg::t_prod  r_pb [3][3];
    tvg_pkg::t_diff  r_m0_s2 [3];
    tvg_pkg::t_cof   n_cof [3][3];
    tvg_pkg::t_cof   r_cof [3][3];
    tvg_pkg::t_diff  r_m0_s3 [3];
    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    logic en1, en2, en3;

    assign en3 = !r_v3 || i_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_in.ready = en1;

    always_comb begin
        pt[0][0] = i_in.a_x; pt[0][1] = i_in.a_y; pt[0][2] = i_in.a_z;
        pt[1][0] = i_in.b_x; pt[1][1] = i_in.b_y; pt[1][2] = i_in.b_z;
        pt[2][0] = i_in.c_x; pt[2][1] = i_in.c_y; pt[2][2] = i_in.c_z;
        pt[3][0] = i_in.d_x; pt[3][1] = i_in.d_y; pt[3][2] = i_in.d_z;
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                // column k is D minus corner k
                n_m[p][k] = {pt[3][p][tvg_pkg::COORD_W-1], pt[3][p]}
                          - {pt[k][p][tvg_pkg::COORD_W-1], pt[k][p]};
            end
        end
    end

    for (genvar gp = 0; gp < 3; gp++) begin : g_row
        localparam int R1 = (gp + 1) % 3;
        localparam int R2 = (gp + 2) % 3;
        for (genvar gk = 0; gk < 3; gk++) begin : g_col
            localparam int C1 = (gk + 1) % 3;
            localparam int C2 = (gk + 2) % 3;
            assign n_pa[gp][gk] = $signed(r_m[R1][C1]) * $signed(r_m[R2][C2]);
            assign n_pb[gp][gk] = $signed(r_m[R1][C2]) * $signed(r_m[R2][C1]);
            assign n_cof[gp][gk] = {r_pa[gp][gk][tvg_pkg::PROD_W-1], r_pa[gp][gk]}
                                 - {r_pb[gp][gk][tvg_pkg::PROD_W-1], r_pb[gp][gk]};
            assign o_bus.cof[gp][gk] = r_cof[gp][gk];
        end
        assign o_bus.m0[gp] = r_m0_s3[gp];
    end

    always_comb begin
        n_v1 = en1 ? i_in.valid : r_v1;
        n_v2 = en2 ? r_v1 : r_v2;
        n_v3 = en3 ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                if (en1) begin
                    r_m[p][k] <= n_m[p][k];
                end
                if (en2) begin
                    r_pa[p][k] <= n_pa[p][k];
                    r_pb[p][k] <= n_pb[p][k];
                end
                if (en3) begin
                    r_cof[p][k] <= n_cof[p][k];
                end
            end
            if (en2) begin
                r_m0_s2[p] <= r_m[0][p];
            end
            if (en3) begin
                r_m0_s3[p] <= r_m0_s2[p];
            end
        end
    end

    assign o_valid = r_v3;

endmodule

`default_nettype wire

// ===== sv/tvg_det.sv =====
`default_nettype none

module tvg_det (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  tvg_pkg::t_cof_bus      i_bus,
    input  wire logic              i_valid,
    output logic                   o_ready,
    output tvg_pkg::t_res_bus      o_res,
    output logic                   o_valid,
    input  wire logic              i_ready
);

    tvg_pkg::t_det  n_dp [3];
    tvg_pkg::t_det  r_dp [3];
    tvg_pkg::t_grad n_g [4][3];
    tvg_pkg::t_grad r_g4 [4][3];
    tvg_pkg::t_grad r_g5 [4][3];
    tvg_pkg::t_det  n_det;
    tvg_pkg::t_det  r_det;
    logic r_v4, r_v5;
    logic n_v4, n_v5;
    logic en4, en5;

    assign en5 = !r_v5 || i_ready;
    assign en4 = !r_v4 || en5;
    assign o_ready = en4;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_dp[k] = $signed(i_bus.m0[k]) * $signed(i_bus.cof[0][k]);
        end
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                n_g[k][p] = -{i_bus.cof[p][k][tvg_pkg::COF_W-1], i_bus.cof[p][k]};
            end
            // corner D takes the row sum of cofactors
            n_g[3][p] = {i_bus.cof[p][0][tvg_pkg::COF_W-1], i_bus.cof[p][0]}
                      + {i_bus.cof[p][1][tvg_pkg::COF_W-1], i_bus.cof[p][1]}
                      + {i_bus.cof[p][2][tvg_pkg::COF_W-1], i_bus.cof[p][2]};
        end
        // exact result fits, so wrapping partial sums are harmless
        n_det = r_dp[0] + r_dp[1] + r_dp[2];
        n_v4 = en4 ? i_valid : r_v4;
        n_v5 = en5 ? r_v4 : r_v5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= n_v4;
            r_v5 <= n_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int k = 0; k < 3; k++) begin
                r_dp[k] <= n_dp[k];
            end
            for (int c = 0; c < 4; c++) begin
                for (int p = 0; p < 3; p++) begin
                    r_g4[c][p] <= n_g[c][p];
                end
            end
        end
        if (en5) begin
            r_det <= n_det;
            for (int c = 0; c < 4; c++) begin
                for (int p = 0; p < 3; p++) begin
                    r_g5[c][p] <= r_g4[c][p];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int p = 0; p < 3; p++) begin
                o_res.grad[c][p] = r_g5[c][p];
            end
        end
        o_res.det = r_det;
    end

    assign o_valid = r_v5;

endmodule

`default_nettype wire

// ===== sv/tvg_serial.sv =====
`default_nettype none

module tvg_serial (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  tvg_pkg::t_res_bus      i_res,
    input  wire logic              i_valid,
    output logic                   o_ready,
    tvg_out_if.source              o_out
);

    tvg_pkg::t_res_bus             r_res;
    logic                          r_busy;
    logic                          n_busy;
    logic [tvg_pkg::CORNER_W-1:0]  r_cnt;
    logic [tvg_pkg::CORNER_W-1:0]  n_cnt;
    logic                          xfer;
    logic                          done;
    logic                          accept;

    assign xfer   = r_busy && o_out.ready;
    assign done   = xfer && (r_cnt == tvg_pkg::CORNER_D);
    // next tetrahedron loads in the same cycle the corner D transaction leaves
    assign o_ready = !r_busy || done;
    assign accept = i_valid && o_ready;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (accept) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (xfer) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= i_res;
        end
    end

    always_comb begin
        o_out.valid      = r_busy;
        o_out.corner     = r_cnt;
        o_out.grad_x     = r_res.grad[r_cnt][0];
        o_out.grad_y     = r_res.grad[r_cnt][1];
        o_out.grad_z     = r_res.grad[r_cnt][2];
        o_out.six_volume = r_res.det;
        o_out.last       = (r_cnt == tvg_pkg::CORNER_D);
    end

endmodule

`default_nettype wire

// ===== sv/tetra_volume_gradient.sv =====
// Tetrahedron signed volume and volume gradient, all scaled by six. Each input
// transaction carries corners A, B, C, D as signed 16-bit grid coordinates; the
// block answers with four output transactions in corner order A, B, C, D, each
// holding that corner's gradient (x, y, z) and the signed determinant of the
// matrix with columns D-A, D-B, D-C; last marks the corner D transaction. All
// results are exact integers. The arithmetic is a five-stage pipeline
// (differences, cofactor products, cofactors, determinant products, determinant
// sum). The result port delivers one corner per cycle while the receiver is
// ready; a new input is taken while earlier ones are still in the pipeline or
// being delivered, and backpressure on the result port stalls the pipeline
// without losing or repeating anything.
`default_nettype none

module tetra_volume_gradient (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tvg_in_if.sink      i_in,
    tvg_out_if.source   o_out
);

    tvg_pkg::t_cof_bus  cof_bus;
    logic               cof_valid;
    logic               cof_ready;
    tvg_pkg::t_res_bus  res_bus;
    logic               res_valid;
    logic               res_ready;

    tvg_cofactor u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_bus   (cof_bus),
        .o_valid (cof_valid),
        .i_ready (cof_ready)
    );

    tvg_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bus   (cof_bus),
        .i_valid (cof_valid),
        .o_ready (cof_ready),
        .o_res   (res_bus),
        .o_valid (res_valid),
        .i_ready (res_ready)
    );

    tvg_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res_bus),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
